FILE: rtl/first_fit_region_allocator_assert.svh
// Assertion macros for the first-fit region allocator.
// Used by rtl/first_fit_region_allocator.sv; needs clk and rst in scope.
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFRA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator assertion failed");
`define FFRA_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("allocator forbidden condition seen");
`else
`define FFRA_ASSERT(label, prop)
`define FFRA_NEVER(label, cond)
`endif
`endif

FILE: rtl/ffra_pkg.sv
// Constants, header entry type, codes and state type of the allocator.
// Used by rtl/first_fit_region_allocator.sv; depends on nothing.
package ffra_pkg;

  localparam int REGION_MAX_BYTES = 65536;
  localparam int GRANULE_BYTES    = 8;
  localparam int GRAN_SHIFT       = 3;
  localparam int HDR_BYTES        = 24;
  localparam int HDR_SPAN  = (HDR_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
  localparam int HDR_GRAN  = HDR_SPAN / GRANULE_BYTES;
  localparam int MIN_REGION  = HDR_SPAN + GRANULE_BYTES;
  localparam int STORE_DEPTH = REGION_MAX_BYTES / GRANULE_BYTES;
  localparam int SLOT_W = 13;
  localparam int PAY_W  = 14;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic             valid;
    logic             free;
    logic [PAY_W-1:0] pay;   // payload in granules
  } hdr_t;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_CHK, S_A_SPLIT, S_F_CHKS, S_F_CHKN, S_F_PWK, S_F_WRS, S_RESP
  } state_t;

endpackage

FILE: rtl/first_fit_region_allocator.sv
// First-fit region allocator: header store memory, walker state machine, counters.
// Depends on rtl/ffra_pkg.sv and rtl/first_fit_region_allocator_assert.svh.
//
// Manages a region of up to 64 KiB tiled in address order by blocks, each a
// 24-byte header and a payload of whole 8-byte granules; the headers sit in one
// 8192-entry memory with a registered read. An allocate request walks the block
// chain first-fit, one header per cycle, and may split the chosen block. A free
// request reads every block in front of the freed one in turn, since the walk
// to find the previous neighbour goes through the single read port. After reset,
// after a write of region_bytes and on a region reset request, the store is
// cleared one entry per cycle, during which no request is taken (configuration
// writes still are). One request is handled at a time; a finished result waits
// in an output register while the next request is accepted.
`include "first_fit_region_allocator_assert.svh"
module first_fit_region_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] region_bytes,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] request_bytes,
  input  logic [15:0] payload_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] granted_address,
  output logic [16:0] granted_bytes,
  output logic [16:0] used_bytes,
  output logic [16:0] peak_bytes
);
  import ffra_pkg::*;

  hdr_t mem [STORE_DEPTH];
  hdr_t rd_data;
  slot_t rd_slot, wr_slot;
  hdr_t wr_data;
  logic wr_en;

  state_t st, st_next;
  logic [16:0] region_size, chain_end, used_count, peak_count;
  logic [16:0] blk, prev;
  logic [PAY_W-1:0] need_g, pay_s;
  slot_t rem_slot, n_slot, clr_cnt;
  logic [PAY_W-1:0] rem_pay;
  logic kill_s, pend_resp;
  status_t res_status;
  logic [15:0] res_addr;
  logic [16:0] res_bytes;

  // Combinational helpers
  logic [16:0] cfg_clamped, walk_base, nxt;
  logic [PAY_W-1:0] init_pay, new_pay;
  logic fit, split, free_bad;
  logic [15:0] fb;
  logic [16:0] want, need_sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    rd_data <= mem[rd_slot];
  end

  always_comb begin
    if (region_bytes < 17'(MIN_REGION)) begin
      cfg_clamped = 17'(MIN_REGION);
    end else if (region_bytes > 17'(REGION_MAX_BYTES)) begin
      cfg_clamped = 17'(REGION_MAX_BYTES);
    end else begin
      cfg_clamped = region_bytes;
    end
  end

  assign init_pay  = PAY_W'((region_size - 17'(HDR_SPAN)) >> GRAN_SHIFT);
  assign walk_base = (st == S_F_PWK) ? prev : blk;
  assign nxt       = walk_base + 17'(HDR_SPAN) + {rd_data.pay, 3'b000};
  assign fit       = rd_data.free && (rd_data.pay >= need_g);
  assign split     = {1'b0, rd_data.pay} >= ({1'b0, need_g} + 15'(HDR_GRAN + 1));
  assign new_pay   = split ? need_g : rd_data.pay;
  assign want      = (request_bytes == 16'd0) ? 17'd1 : {1'b0, request_bytes};
  assign need_sum  = want + 17'(GRANULE_BYTES - 1);
  assign fb        = payload_address - 16'(HDR_SPAN);
  assign free_bad  = ({1'b0, payload_address} >= region_size)
                     || (payload_address < 16'(HDR_SPAN))
                     || (fb[GRAN_SHIFT-1:0] != '0)
                     || ({1'b0, fb} >= chain_end);

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
    end else if (cfg_valid) begin
      st <= S_CLR;
    end else begin
      st <= st_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    st_next = st;
    rd_slot = '0;
    wr_en   = 1'b0;
    wr_slot = '0;
    wr_data = '0;
    unique case (st)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_slot = clr_cnt;
        if (clr_cnt == '0) begin
          wr_data = '{valid: 1'b1, free: 1'b1, pay: init_pay};
        end
        if (clr_cnt == slot_t'(STORE_DEPTH - 1)) begin
          st_next = pend_resp ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          priority case (req_type)
            REQ_ALLOC: st_next = S_A_CHK;
            REQ_FREE: begin
              rd_slot = fb[15:GRAN_SHIFT];
              st_next = free_bad ? S_RESP : S_F_CHKS;
            end
            REQ_RESET: st_next = S_CLR;
            default:   st_next = S_RESP;
          endcase
        end
      end
      S_A_CHK: begin
        if (fit) begin
          wr_en   = 1'b1;
          wr_slot = blk[15:GRAN_SHIFT];
          wr_data = '{valid: 1'b1, free: 1'b0, pay: new_pay};
          st_next = split ? S_A_SPLIT : S_RESP;
        end else if (nxt >= chain_end) begin
          st_next = S_RESP;
        end else begin
          rd_slot = nxt[15:GRAN_SHIFT];
        end
      end
      S_A_SPLIT: begin
        wr_en   = 1'b1;
        wr_slot = rem_slot;
        wr_data = '{valid: 1'b1, free: 1'b1, pay: rem_pay};
        st_next = S_RESP;
      end
      S_F_CHKS: begin
        if (!rd_data.valid || rd_data.free) begin
          st_next = S_RESP;
        end else if (nxt < chain_end) begin
          rd_slot = nxt[15:GRAN_SHIFT];
          st_next = S_F_CHKN;
        end else begin
          st_next = (blk != '0) ? S_F_PWK : S_F_WRS;
        end
      end
      S_F_CHKN: begin
        if (rd_data.free) begin
          wr_en   = 1'b1;
          wr_slot = n_slot;
        end
        st_next = (blk != '0) ? S_F_PWK : S_F_WRS;
      end
      S_F_PWK: begin
        if (nxt == blk) begin
          if (rd_data.free) begin
            wr_en   = 1'b1;
            wr_slot = prev[15:GRAN_SHIFT];
            wr_data = '{valid: 1'b1, free: 1'b1,
                        pay: rd_data.pay + PAY_W'(HDR_GRAN) + pay_s};
          end
          st_next = S_F_WRS;
        end else if (nxt >= chain_end) begin
          st_next = S_F_WRS;
        end else begin
          rd_slot = nxt[15:GRAN_SHIFT];
        end
      end
      S_F_WRS: begin
        wr_en   = 1'b1;
        wr_slot = blk[15:GRAN_SHIFT];
        if (!kill_s) begin
          wr_data = '{valid: 1'b1, free: 1'b1, pay: pay_s};
        end
        st_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= 17'(REGION_MAX_BYTES);
      chain_end   <= 17'(REGION_MAX_BYTES);
      used_count  <= '0;
      peak_count  <= '0;
      clr_cnt     <= '0;
      pend_resp   <= 1'b0;
      out_valid   <= 1'b0;
      kill_s      <= 1'b0;
    end else begin
      if (!cfg_valid && st == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        region_size <= cfg_clamped;
        chain_end   <= 17'(HDR_SPAN)
                       + ((cfg_clamped - 17'(HDR_SPAN)) & ~17'(GRANULE_BYTES - 1));
        used_count  <= '0;
        peak_count  <= '0;
        clr_cnt     <= '0;
        pend_resp   <= 1'b0;
      end else begin
        unique case (st)
          S_CLR: begin
            chain_end <= 17'(HDR_SPAN) + {init_pay, 3'b000};
            clr_cnt   <= clr_cnt + slot_t'(1);
          end
          S_IDLE: begin
            if (in_valid && req_type == REQ_RESET) begin
              used_count <= '0;
              clr_cnt    <= '0;
              pend_resp  <= 1'b1;
            end
            kill_s <= 1'b0;
          end
          S_A_CHK: begin
            if (fit) begin
              used_count <= used_count + 17'(HDR_SPAN) + {new_pay, 3'b000};
              if (used_count + 17'(HDR_SPAN) + {new_pay, 3'b000} > peak_count) begin
                peak_count <= used_count + 17'(HDR_SPAN) + {new_pay, 3'b000};
              end
            end
          end
          S_F_CHKS: begin
            if (rd_data.valid && !rd_data.free) begin
              used_count <= used_count - 17'(HDR_SPAN) - {rd_data.pay, 3'b000};
            end
          end
          S_F_PWK: begin
            if (nxt == blk && rd_data.free) begin
              kill_s <= 1'b1;
            end
          end
          S_RESP: begin
            if (!out_valid || out_ready) begin
              pend_resp <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Request payload and result staging.
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        res_addr  <= '0;
        res_bytes <= '0;
        need_g    <= PAY_W'(need_sum >> GRAN_SHIFT);
        blk       <= (req_type == REQ_FREE) ? {1'b0, fb} : '0;
        if (req_type == REQ_FREE) begin
          res_status <= free_bad ? ST_INVALID : ST_DONE;
        end else if (req_type == REQ_ALLOC || req_type == REQ_RESET) begin
          res_status <= ST_DONE;
        end else begin
          res_status <= ST_INVALID;
        end
      end
      S_A_CHK: begin
        if (fit) begin
          res_status <= ST_DONE;
          res_addr   <= 16'(blk + 17'(HDR_SPAN));
          res_bytes  <= {new_pay, 3'b000};
          rem_slot   <= blk[15:GRAN_SHIFT] + slot_t'(HDR_GRAN) + need_g[SLOT_W-1:0];
          rem_pay    <= rd_data.pay - need_g - PAY_W'(HDR_GRAN);
        end else if (nxt >= chain_end) begin
          res_status <= ST_NO_FIT;
        end else begin
          blk <= nxt;
        end
      end
      S_F_CHKS: begin
        if (!rd_data.valid || rd_data.free) begin
          res_status <= ST_INVALID;
        end
        pay_s  <= rd_data.pay;
        n_slot <= nxt[15:GRAN_SHIFT];
        prev   <= '0;
      end
      S_F_CHKN: begin
        if (rd_data.free) begin
          pay_s <= pay_s + PAY_W'(HDR_GRAN) + rd_data.pay;
        end
      end
      S_F_PWK: begin
        prev <= nxt;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          status          <= res_status;
          granted_address <= res_addr;
          granted_bytes   <= res_bytes;
          used_bytes      <= used_count;
          peak_bytes      <= peak_count;
        end
      end
      default: ;
    endcase
  end

  `FFRA_ASSERT(a_used_in_region, used_count <= chain_end)
  `FFRA_ASSERT(a_chain_in_region, chain_end <= region_size)
  `FFRA_ASSERT(a_peak, (st == S_IDLE) |-> (peak_count >= used_count))
  `FFRA_NEVER(a_grant_on_fail, out_valid && (status != ST_DONE) && (granted_bytes != '0))
  `FFRA_NEVER(a_busy_accept, in_ready && (st != S_IDLE))

endmodule
